// File: hdl/gmb_pkg.sv
// Package for the lat/lon grid running-mean binner.
// Holds grid geometry, field widths, request/cell types and state codes.
// No dependencies.
package gmb_pkg;

    localparam int LAT_CELLS  = 180;
    localparam int LON_CELLS  = 360;
    localparam int COUNT_BITS = 16;

    localparam int CELLS      = LAT_CELLS * LON_CELLS;
    localparam int CELL_BITS  = $clog2(CELLS);
    localparam int ROW_BITS   = $clog2(LAT_CELLS);
    localparam int COL_BITS   = $clog2(LON_CELLS);
    localparam int IDX_W      = 12;

    localparam int VAL_BITS   = 20;
    localparam int MEAN_BITS  = 20;
    localparam int OCNT_BITS  = 16;
    localparam int SUM_BITS   = VAL_BITS + COUNT_BITS;
    localparam int STEP_BITS  = $clog2(MEAN_BITS);

    localparam int N_LANES    = 3;
    localparam logic [1:0] LANE_SW   = 2'd0;
    localparam logic [1:0] LANE_LW   = 2'd1;
    localparam logic [1:0] LANE_ALB  = 2'd2;
    localparam logic [1:0] LANE_LAST = LANE_ALB;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;
    localparam int LAT_W        = 18;
    localparam int DEG_SHIFT    = 8;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [19:0] FLUX_LIMIT_RST   = 20'd160000;
    localparam logic [19:0] ALBEDO_LIMIT_RST = 20'd65536;
    localparam logic [15:0] MIN_LAT_RST      = 16'hA600;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FLUX_LIMIT   = 2'd0,
        CFG_ALBEDO_LIMIT = 2'd1,
        CFG_MIN_LATITUDE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_bstate;

    typedef struct packed {
        t_cmd                             cmd;
        logic [CELL_BITS-1:0]             addr;
        logic [N_LANES-1:0]               ok;
        logic [N_LANES-1:0][VAL_BITS-1:0] val;
    } t_op;

    typedef struct packed {
        logic [N_LANES-1:0][SUM_BITS-1:0]   sum;
        logic [N_LANES-1:0][COUNT_BITS-1:0] tally;
    } t_cell;

endpackage

// File: hdl/gmb_ifs.sv
// Request, result and register-write channels of the grid binner.
// Depends on gmb_pkg.
interface gmb_req_if;
    import gmb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [15:0]          colatitude;
    logic [16:0]          longitude;
    logic [VAL_BITS-1:0]  sw_flux;
    logic [VAL_BITS-1:0]  lw_flux;
    logic [VAL_BITS-1:0]  albedo;
    logic [7:0]           cell_row;
    logic [8:0]           cell_col;
    modport source (output valid, cmd, colatitude, longitude, sw_flux, lw_flux, albedo,
                    cell_row, cell_col, input ready);
    modport sink   (input valid, cmd, colatitude, longitude, sw_flux, lw_flux, albedo,
                    cell_row, cell_col, output ready);
endinterface

interface gmb_res_if;
    import gmb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [MEAN_BITS-1:0] sw_mean;
    logic [OCNT_BITS-1:0] sw_count;
    logic [MEAN_BITS-1:0] lw_mean;
    logic [OCNT_BITS-1:0] lw_count;
    logic [MEAN_BITS-1:0] alb_mean;
    logic [OCNT_BITS-1:0] albedo_count;
    modport source (output valid, sw_mean, sw_count, lw_mean, lw_count, alb_mean,
                    albedo_count, input ready);
    modport sink   (input valid, sw_mean, sw_count, lw_mean, lw_count, alb_mean,
                    albedo_count, output ready);
endinterface

interface gmb_cfg_if;
    import gmb_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/gmb_front.sv
// Front end: register file, request classification and cell address.
// Depends on gmb_pkg and gmb_ifs.
module gmb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gmb_req_if.sink         i_req,
    gmb_cfg_if.sink         i_cfg,
    input  logic            i_clearing,
    input  logic            i_full,
    output logic            o_push,
    output gmb_pkg::t_op    o_op
);
    import gmb_pkg::*;

    logic [19:0]              r_flux_lim;
    logic [19:0]              r_alb_lim;
    logic [15:0]              r_min_lat;
    logic                     r_valid;
    t_op                      r_op;

    logic                     accept;
    logic signed [LAT_W-1:0]  lat;
    logic signed [LAT_W-1:0]  span;
    logic signed [LAT_W-1:0]  min_lat;
    logic                     in_band;
    logic [IDX_W-1:0]         row_raw;
    logic [IDX_W-1:0]         col_raw;
    logic [IDX_W-1:0]         row_c;
    logic [IDX_W-1:0]         col_c;
    t_cmd                     cmd;
    t_op                      n_op;
    logic                     keep;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] x,
                                                   input logic [IDX_W-1:0] n);
        return (x >= n) ? n - 1'b1 : x;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !i_clearing && (!r_valid || !i_full);
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = r_valid;
    assign o_op        = r_op;

    always_comb begin
        cmd     = t_cmd'(i_req.cmd);
        lat     = LAT_W'(QUARTER_TURN) - $signed({2'b00, i_req.colatitude});
        span    = LAT_W'(HALF_TURN) - $signed({2'b00, i_req.colatitude});
        min_lat = {{(LAT_W-16){r_min_lat[15]}}, r_min_lat};
        in_band = lat > min_lat;
        if (cmd == CMD_READ) begin
            row_raw = IDX_W'(i_req.cell_row);
            col_raw = IDX_W'(i_req.cell_col);
        end else begin
            row_raw = span[LAT_W-1] ? '0 : IDX_W'(span[LAT_W-2:DEG_SHIFT]);
            col_raw = IDX_W'(i_req.longitude[16:DEG_SHIFT]);
        end
        row_c = clamp_idx(row_raw, IDX_W'(LAT_CELLS));
        col_c = clamp_idx(col_raw, IDX_W'(LON_CELLS));
        n_op.cmd  = cmd;
        n_op.addr = CELL_BITS'(row_c[ROW_BITS-1:0]) * CELL_BITS'(LON_CELLS)
                  + CELL_BITS'(col_c[COL_BITS-1:0]);
        n_op.val[LANE_SW]  = i_req.sw_flux;
        n_op.val[LANE_LW]  = i_req.lw_flux;
        n_op.val[LANE_ALB] = i_req.albedo;
        n_op.ok[LANE_SW]   = i_req.sw_flux < r_flux_lim;
        n_op.ok[LANE_LW]   = i_req.lw_flux < r_flux_lim;
        n_op.ok[LANE_ALB]  = i_req.albedo <= r_alb_lim;
        keep = (cmd == CMD_READ) || in_band;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flux_lim <= FLUX_LIMIT_RST;
            r_alb_lim  <= ALBEDO_LIMIT_RST;
            r_min_lat  <= MIN_LAT_RST;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_FLUX_LIMIT:   r_flux_lim <= i_cfg.data;
                    CFG_ALBEDO_LIMIT: r_alb_lim  <= i_cfg.data;
                    CFG_MIN_LATITUDE: r_min_lat  <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_valid <= keep;
            end else if (!i_full) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

// File: hdl/gmb_fifo.sv
// Short request queue between the front end and the cell update engine.
// Depends on gmb_pkg.
module gmb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gmb_pkg::t_op    i_data,
    output logic            o_full,
    output logic            o_valid,
    output gmb_pkg::t_op    o_data,
    input  logic            i_pop
);
    import gmb_pkg::*;

    t_op                   r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr;
    logic [Q_PTR_BITS-1:0] r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic                  push;
    logic                  pop;

    assign o_full  = r_cnt == Q_CNT_BITS'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_q[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule

// File: hdl/gmb_div.sv
// Radix-2 restoring divider: cell sum by cell count, one quotient bit a cycle.
// Depends on gmb_pkg. Quotient is valid when o_done pulses.
module gmb_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [gmb_pkg::SUM_BITS-1:0]      i_sum,
    input  logic [gmb_pkg::COUNT_BITS-1:0]    i_cnt,
    output logic                              o_done,
    output logic [gmb_pkg::MEAN_BITS-1:0]     o_quo
);
    import gmb_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [MEAN_BITS-1:0]  r_dvd;
    logic [MEAN_BITS-1:0]  r_quo;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_comb begin
        trial = {r_rem, r_dvd[MEAN_BITS-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_BITS'(MEAN_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_rem  <= i_sum[SUM_BITS-1:MEAN_BITS];
            r_dvd  <= i_sum[MEAN_BITS-1:0];
            r_den  <= i_cnt;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            r_rem  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_dvd  <= {r_dvd[MEAN_BITS-2:0], 1'b0};
            r_quo  <= {r_quo[MEAN_BITS-2:0], ge};
        end
    end

endmodule

// File: hdl/gmb_back.sv
// Back end: cell store, read-modify-write of sums and counts, mean readout.
// Depends on gmb_pkg, gmb_ifs and gmb_div.
module gmb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  gmb_pkg::t_op    i_q_op,
    output logic            o_q_pop,
    output logic            o_clearing,
    gmb_res_if.source       o_res
);
    import gmb_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int CW = (COUNT_BITS > OCNT_BITS) ? COUNT_BITS : OCNT_BITS;

    t_cell                 r_mem [CELLS];
    t_cell                 r_rd;
    t_cell                 r_cell;
    t_op                   r_op;
    t_bstate               r_state;
    t_bstate               n_state;
    logic [CELL_BITS-1:0]  r_clr;
    logic [1:0]            r_lane;
    logic                  r_go;
    logic                  n_go;
    logic                  r_out_valid;
    logic [N_LANES-1:0][MEAN_BITS-1:0] r_mean;
    logic [N_LANES-1:0][MEAN_BITS-1:0] r_res_mean;
    logic [N_LANES-1:0][OCNT_BITS-1:0] r_res_cnt;

    logic                  we;
    logic [CELL_BITS-1:0]  waddr;
    t_cell                 wdata;
    t_cell                 upd;
    logic                  load_out;
    logic                  div_done;
    logic [MEAN_BITS-1:0]  div_quo;

    function automatic logic [OCNT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] c);
        logic [CW-1:0] w;
        w = CW'(c);
        return (w > CW'({OCNT_BITS{1'b1}})) ? {OCNT_BITS{1'b1}} : w[OCNT_BITS-1:0];
    endfunction

    gmb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_sum   (r_cell.sum[r_lane]),
        .i_cnt   (r_cell.tally[r_lane]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_clearing         = r_state == ST_CLEAR;
    assign o_res.valid        = r_out_valid;
    assign o_res.sw_mean      = r_res_mean[LANE_SW];
    assign o_res.lw_mean      = r_res_mean[LANE_LW];
    assign o_res.alb_mean     = r_res_mean[LANE_ALB];
    assign o_res.sw_count     = r_res_cnt[LANE_SW];
    assign o_res.lw_count     = r_res_cnt[LANE_LW];
    assign o_res.albedo_count = r_res_cnt[LANE_ALB];

    always_comb begin
        upd = r_rd;
        for (int k = 0; k < N_LANES; k++) begin
            if (r_op.ok[k] && r_rd.tally[k] != COUNT_MAX) begin
                upd.sum[k]   = r_rd.sum[k] + SUM_BITS'(r_op.val[k]);
                upd.tally[k] = r_rd.tally[k] + 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == CELL_BITS'(CELLS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_q_valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = (r_op.cmd == CMD_ACCUM) ? ST_IDLE : ST_DIV;
            ST_DIV:   if (div_done && r_lane == LANE_LAST) n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid) n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop  = 1'b0;
        we       = 1'b0;
        waddr    = r_op.addr;
        wdata    = upd;
        n_go     = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
            end
            ST_IDLE: o_q_pop = i_q_valid;
            ST_LOAD: begin
                we   = r_op.cmd == CMD_ACCUM;
                n_go = r_op.cmd == CMD_READ;
            end
            ST_DIV:  n_go = div_done && r_lane != LANE_LAST;
            ST_OUT:  load_out = !r_out_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op <= i_q_op;
        end
        if (r_state == ST_LOAD) begin
            r_cell <= r_rd;
            r_lane <= LANE_SW;
        end else if (div_done) begin
            r_mean[r_lane] <= (r_cell.tally[r_lane] == '0) ? '0 : div_quo;
            r_lane         <= r_lane + 1'b1;
        end
        if (load_out) begin
            r_res_mean <= r_mean;
            for (int k = 0; k < N_LANES; k++) begin
                r_res_cnt[k] <= sat_cnt(r_cell.tally[k]);
            end
        end
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[i_q_op.addr];
    end

endmodule

// File: hdl/geo_grid_running_mean_binner_core.sv
// Top level of the lat/lon grid running-mean binner.
// Accumulate requests: one store read, then one write in the cell update engine.
// Read requests: one store read in the engine, then a division for each lane in turn;
// the three means share one divider.
// Reset clears the store; requests wait for it, register writes do not.
module geo_grid_running_mean_binner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmb_req_if.sink     i_req,
    gmb_cfg_if.sink     i_cfg,
    gmb_res_if.source   o_res
);
    import gmb_pkg::*;

    logic clearing;
    logic full;
    logic push;
    t_op  push_op;
    logic q_valid;
    t_op  q_op;
    logic q_pop;

    gmb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (i_cfg),
        .i_clearing (clearing),
        .i_full     (full),
        .o_push     (push),
        .o_op       (push_op)
    );

    gmb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_op),
        .i_pop   (q_pop)
    );

    gmb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_op     (q_op),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_res      (o_res)
    );

endmodule

// File: tb/geo_grid_running_mean_binner_core_test.sv
`timescale 1ns / 100ps
// Testbench for geo_grid_running_mean_binner_core: footprint and cell-read requests from a
// bursty sender, results taken by a stalling sink and checked against an in-bench grid model.
// Depends on gmb_pkg, the channel interfaces in gmb_ifs and the core itself.
module geo_grid_running_mean_binner_core_test;
    import gmb_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int COUNT_CAP     = (1 << COUNT_BITS) - 1;
    localparam int N_HOT         = 8;
    localparam int N_PILE        = 40;
    localparam int SAT_ROW       = 90;
    localparam int SAT_COL       = 180;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        t_cmd                               cmd;
        logic [15:0]                        colat;
        logic [16:0]                        lon;
        logic [N_LANES-1:0][VAL_BITS-1:0]   val;
        logic [7:0]                         row;
        logic [8:0]                         col;
    } t_footprint_req;

    typedef struct {
        logic [N_LANES-1:0][MEAN_BITS-1:0]  mean;
        logic [N_LANES-1:0][OCNT_BITS-1:0]  count;
    } t_cell_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gmb_req_if req_ch ();
    gmb_cfg_if cfg_ch ();
    gmb_res_if res_ch ();

    geo_grid_running_mean_binner_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // grid model
    bit [SUM_BITS-1:0]   grid_sum   [N_LANES][CELLS];
    bit [COUNT_BITS-1:0] grid_tally [N_LANES][CELLS];
    logic [VAL_BITS-1:0] flux_lim_q;
    logic [VAL_BITS-1:0] alb_lim_q;
    logic signed [15:0]  min_lat_q;

    t_cell_report pending_reports [$];
    string        lane_tag [N_LANES] = '{"sw", "lw", "alb"};
    int           errors = 0;

    int hot_row [N_HOT];
    int hot_col [N_HOT];
    bit gaps_on;
    int burst_left;
    int sink_mode = 0;
    int sink_hold = 0;

    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(negedge i_clk) begin
        if (sink_hold == 0) begin
            sink_mode = $urandom_range(0, 2);
            sink_hold = $urandom_range(16, 160);
        end
        sink_hold--;
        case (sink_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            default: res_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_cell_report want;
        t_cell_report got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.mean[LANE_SW]   = res_ch.sw_mean;
            got.mean[LANE_LW]   = res_ch.lw_mean;
            got.mean[LANE_ALB]  = res_ch.alb_mean;
            got.count[LANE_SW]  = res_ch.sw_count;
            got.count[LANE_LW]  = res_ch.lw_count;
            got.count[LANE_ALB] = res_ch.albedo_count;
            if (pending_reports.size() == 0) begin
                $display("%0t: result with none expected, sw_mean %0d sw_count %0d",
                         $time, got.mean[LANE_SW], got.count[LANE_SW]);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                for (int l = 0; l < N_LANES; l++) begin
                    if (got.mean[l] !== want.mean[l]) begin
                        $display("%0t: %s_mean expected %0d actual %0d",
                                 $time, lane_tag[l], want.mean[l], got.mean[l]);
                        errors++;
                    end
                    if (got.count[l] !== want.count[l]) begin
                        $display("%0t: %s_count expected %0d actual %0d",
                                 $time, lane_tag[l], want.count[l], got.count[l]);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic void predict_request(t_footprint_req r);
        int           lat;
        int           span;
        int           row;
        int           col;
        int           cidx;
        bit           accept [N_LANES];
        bit [SUM_BITS-1:0] q;
        t_cell_report rep;
        if (r.cmd == CMD_ACCUM) begin
            lat  = QUARTER_TURN - int'(r.colat);
            span = HALF_TURN - int'(r.colat);
            if (lat <= int'(min_lat_q))
                return;
            row = (span < 0) ? 0 : span / 256;
            if (row >= LAT_CELLS)
                row = LAT_CELLS - 1;
            col = int'(r.lon) / 256;
            if (col >= LON_CELLS)
                col = LON_CELLS - 1;
            cidx = row * LON_CELLS + col;
            accept[LANE_SW]  = r.val[LANE_SW] < flux_lim_q;
            accept[LANE_LW]  = r.val[LANE_LW] < flux_lim_q;
            accept[LANE_ALB] = r.val[LANE_ALB] <= alb_lim_q;
            for (int l = 0; l < N_LANES; l++) begin
                if (accept[l] && grid_tally[l][cidx] < COUNT_CAP) begin
                    grid_sum[l][cidx]   += SUM_BITS'(r.val[l]);
                    grid_tally[l][cidx] += 1'b1;
                end
            end
        end else begin
            row  = (int'(r.row) >= LAT_CELLS) ? LAT_CELLS - 1 : int'(r.row);
            col  = (int'(r.col) >= LON_CELLS) ? LON_CELLS - 1 : int'(r.col);
            cidx = row * LON_CELLS + col;
            for (int l = 0; l < N_LANES; l++) begin
                q = (grid_tally[l][cidx] != 0) ? grid_sum[l][cidx] / grid_tally[l][cidx] : '0;
                rep.mean[l]  = q[MEAN_BITS-1:0];
                rep.count[l] = (longint'(grid_tally[l][cidx]) > 65535) ? 16'hFFFF
                                                                       : 16'(grid_tally[l][cidx]);
            end
            pending_reports.push_back(rep);
        end
    endfunction

    function automatic t_footprint_req accum_at(int colat, int lon, int sw, int lw, int alb);
        t_footprint_req r;
        r.cmd           = CMD_ACCUM;
        r.colat         = 16'(colat);
        r.lon           = 17'(lon);
        r.val[LANE_SW]  = 20'(sw);
        r.val[LANE_LW]  = 20'(lw);
        r.val[LANE_ALB] = 20'(alb);
        r.row           = 8'($urandom);
        r.col           = 9'($urandom);
        return r;
    endfunction

    function automatic t_footprint_req read_cell(int row, int col);
        t_footprint_req r;
        r       = accum_at($urandom, $urandom, $urandom, $urandom, $urandom);
        r.cmd   = CMD_READ;
        r.row   = 8'(row);
        r.col   = 9'(col);
        return r;
    endfunction

    // values clustered around the acceptance limit, plus fill and full-range noise
    function automatic logic [VAL_BITS-1:0] pick_level(logic [VAL_BITS-1:0] lim);
        case ($urandom_range(0, 9))
            0:       return lim - 1'b1;
            1:       return lim;
            2:       return lim + 1'b1;
            3:       return '1;
            4:       return 20'($urandom);
            5:       return '0;
            default: return 20'($urandom_range(0, 170000));
        endcase
    endfunction

    function automatic t_footprint_req make_accum();
        t_footprint_req r;
        int             h;
        h = $urandom_range(0, N_HOT - 1);
        r = accum_at($urandom, $urandom, pick_level(flux_lim_q), pick_level(flux_lim_q),
                     pick_level(alb_lim_q));
        if ($urandom_range(0, 7) != 0) begin
            r.colat = 16'(HALF_TURN - (hot_row[h] * 256 + int'($urandom_range(0, 255))));
            r.lon   = 17'(hot_col[h] * 256 + int'($urandom_range(0, 255)));
        end
        return r;
    endfunction

    function automatic t_footprint_req make_read();
        int h;
        h = $urandom_range(0, N_HOT - 1);
        if ($urandom_range(0, 4) != 0)
            return read_cell(hot_row[h], hot_col[h]);
        return read_cell($urandom_range(0, 255), $urandom_range(0, 511));
    endfunction

    task automatic send_req(t_footprint_req r);
        int gap;
        gap = 0;
        @(negedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= r.cmd;
        req_ch.colatitude <= r.colat;
        req_ch.longitude  <= r.lon;
        req_ch.sw_flux    <= r.val[LANE_SW];
        req_ch.lw_flux    <= r.val[LANE_LW];
        req_ch.albedo     <= r.val[LANE_ALB];
        req_ch.cell_row   <= r.row;
        req_ch.cell_col   <= r.col;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(r);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_FLUX_LIMIT:   flux_lim_q = value;
            CFG_ALBEDO_LIMIT: alb_lim_q  = value;
            CFG_MIN_LATITUDE: min_lat_q  = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_grid_edges();
        send_req(read_cell(0, 0));
        send_req(accum_at(0, 0, 100, 200, 300));
        send_req(accum_at(HALF_TURN, 5000, 1, 1, 1));
        send_req(accum_at(65535, 131071, 5, 5, 5));
        send_req(accum_at(HALF_TURN - 1, 92160, 0, 0, 0));
        send_req(accum_at(256, 131071, 159999, 160000, 65536));
        send_req(accum_at(1, 92159, 1048575, 159999, 65537));
        send_req(accum_at(0, 0, 7, 1048575, 1048575));
        send_req(read_cell(179, 0));
        send_req(read_cell(255, 511));
        send_req(read_cell(179, 359));
        send_req(read_cell(0, 359));
        send_req(read_cell(180, 360));
        send_req(accum_at(QUARTER_TURN, SAT_COL * 256, 12345, 54321, 32768));
        send_req(read_cell(SAT_ROW, SAT_COL));
        wait_for_drain();
    endtask

    task automatic test_repeat_cell();
        gaps_on = 1'b0;
        for (int i = 0; i < N_PILE; i++)
            send_req(accum_at(QUARTER_TURN - int'($urandom_range(0, 255)),
                              SAT_COL * 256 + int'($urandom_range(0, 255)),
                              $urandom_range(0, 159999), $urandom_range(0, 159999),
                              $urandom_range(0, 65536)));
        send_req(read_cell(SAT_ROW, SAT_COL));
        wait_for_drain();
        gaps_on = 1'b1;
    endtask

    task automatic run_phase(logic [19:0] flux, logic [19:0] alb, logic [15:0] min_lat, int n);
        wait_for_drain();
        write_reg(CFG_FLUX_LIMIT, flux);
        write_reg(CFG_ALBEDO_LIMIT, alb);
        write_reg(CFG_MIN_LATITUDE, {4'($urandom), min_lat});
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_req(make_read());
            else
                send_req(make_accum());
            if ($urandom_range(0, 59) == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_register_sweep();
        write_reg(CFG_SPARE, 20'($urandom));
        run_phase(20'hFFFFF, 20'hFFFFF, 16'h8000, 110);
        run_phase(20'h00000, 20'h00000, 16'h0000, 60);
        run_phase(20'($urandom), 20'($urandom), 16'(QUARTER_TURN), 50);
        run_phase(FLUX_LIMIT_RST, ALBEDO_LIMIT_RST, MIN_LAT_RST, 150);
        run_phase(20'($urandom_range(1000, 1048575)), 20'($urandom_range(0, 131072)),
                  16'($urandom_range(0, HALF_TURN) - QUARTER_TURN), 150);
        run_phase(20'($urandom_range(140000, 180000)), 20'($urandom_range(60000, 70000)),
                  16'h7FFF, 40);
        run_phase(20'($urandom_range(150000, 170000)), 20'($urandom_range(60000, 70000)),
                  16'(-QUARTER_TURN), 140);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_ACCUM;
        req_ch.colatitude = '0;
        req_ch.longitude  = '0;
        req_ch.sw_flux    = '0;
        req_ch.lw_flux    = '0;
        req_ch.albedo     = '0;
        req_ch.cell_row   = '0;
        req_ch.cell_col   = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        res_ch.ready      = 1'b0;
        gaps_on           = 1'b1;
        burst_left        = 0;
        flux_lim_q        = FLUX_LIMIT_RST;
        alb_lim_q         = ALBEDO_LIMIT_RST;
        min_lat_q         = MIN_LAT_RST;
        hot_row           = '{0, 179, 0, 179, SAT_ROW, 0, 0, 0};
        hot_col           = '{0, 359, 359, 0, SAT_COL, 0, 0, 0};
        for (int h = 5; h < N_HOT; h++) begin
            hot_row[h] = $urandom_range(0, LAT_CELLS - 1);
            hot_col[h] = $urandom_range(0, LON_CELLS - 1);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_grid_edges();
        test_repeat_cell();
        test_register_sweep();
        wait_for_drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
